// ----- rtl/sre_pkg.sv -----
// ----------------------------------------------------------------------------
// sre_pkg
// shared constants, codes and types of the sprite row evaluator
// ----------------------------------------------------------------------------
package sre_pkg;

   // table geometry
   localparam int SPRITE_COUNT = 64;
   localparam int LINE_COUNT   = 152;
   localparam int LINE_AW      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

   // per-line list counters: one per priority list, packed into one memory row
   localparam int PRI_LISTS = 3;
   localparam int COUNT_W   = 7;
   localparam int ROW_W     = PRI_LISTS * COUNT_W;
   localparam int LIST_MAX  = 64;

   // hidden bands
   localparam int HIDE_X_LO = 167;
   localparam int HIDE_HI   = 249;

   // attribute word layout
   localparam int TILE_W       = 9;
   localparam int CHAIN_Y_BIT  = 9;
   localparam int CHAIN_X_BIT  = 10;
   localparam int PRI_LO_BIT   = 11;
   localparam int PRI_HI_BIT   = 12;
   localparam int MONO_PAL_BIT = 13;
   localparam int VFLIP_BIT    = 14;
   localparam int HFLIP_BIT    = 15;

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      REG_SCROLL_X  = 2'd0,
      REG_SCROLL_Y  = 2'd1,
      REG_MONO_MODE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic       mono_mode;
   } cfg_type;

   // one visible sprite handed to the row engine
   typedef struct packed {
      logic [5:0]        sprite_id;
      logic [7:0]        pos_x;
      logic [7:0]        pos_y;
      logic [1:0]        prisel;
      logic [TILE_W-1:0] tile;
      logic              vflip;
      logic              hflip;
      logic [5:0]        palette_base;
   } job_type;

   typedef struct packed {
      logic [7:0]  line;
      logic [1:0]  priority_res;
      logic [5:0]  list_slot;
      logic [5:0]  sprite_id;
      logic [11:0] tile_row;
      logic [7:0]  screen_x;
      logic [5:0]  palette_base;
      logic        hflip;
      logic        last;
   } rec_type;

   typedef logic [PRI_LISTS-1:0][COUNT_W-1:0] count_row_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_READ,
      ENG_WRITE,
      ENG_FLUSH
   } eng_state_type;

endpackage

// ----- rtl/sre_req_if.sv -----
// ----------------------------------------------------------------------------
// sre_req_if
// sprite entry channel: valid, ready and one sprite table entry
// ----------------------------------------------------------------------------
interface sre_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  sprite_index;
   logic [15:0] attribute_word;
   logic [7:0]  x_offset;
   logic [7:0]  y_offset;
   logic [3:0]  color_palette_number;

   modport source (
      output valid, sprite_index, attribute_word, x_offset, y_offset,
             color_palette_number,
      input  ready
   );

   modport sink (
      input  valid, sprite_index, attribute_word, x_offset, y_offset,
             color_palette_number,
      output ready
   );
endinterface

// ----- rtl/sre_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sre_rsp_if
// row record channel: valid, ready and one row record
// ----------------------------------------------------------------------------
interface sre_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  line;
   logic [1:0]  priority_res;
   logic [5:0]  list_slot;
   logic [5:0]  sprite_id;
   logic [11:0] tile_row;
   logic [7:0]  screen_x;
   logic [5:0]  palette_base;
   logic        hflip;
   logic        last;

   modport source (
      output valid, line, priority_res, list_slot, sprite_id, tile_row, screen_x,
             palette_base, hflip, last,
      input  ready
   );

   modport sink (
      input  valid, line, priority_res, list_slot, sprite_id, tile_row, screen_x,
             palette_base, hflip, last,
      output ready
   );
endinterface

// ----- rtl/sprite_row_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// sprite_row_evaluator_unit
// turns sprite table entries into per-line row records with list slots
// ----------------------------------------------------------------------------
// one sprite entry is taken per word on req; a visible sprite yields up to
// eight row records on rsp, the final one flagged with last. for each of
// the eight rows the engine works out the display line; a row that lands
// on a display line gets a read and a write-back of that line's counter
// row in the counter memory, a row that falls off screen is passed over,
// and a flush hands on the last record. a skipped sprite starts no walk.
// the engine works on one entry at a time; req.ready is low while it
// walks rows. a pending record waits in a register in front of the output
// register, so a slow rsp sink stalls the walk only once two records are
// queued. frame start (index 0) clears the counters at once via per-line
// valid bits, so there is no clearing pass and no dead time after reset.
module sprite_row_evaluator_unit (
   input  logic                        clock,
   input  logic                        reset,
   sre_req_if.sink                     req,
   sre_rsp_if.source                   rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sre_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sre_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sre_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import sre_pkg::*;

   cfg_type    cfg;
   job_type    job;
   logic       eng_idle;
   logic       accept;
   logic       in_range;
   logic       frame_start;
   logic       visible;
   logic       start;

   // chain position of the previous entry
   logic [7:0] chain_x_ff, chain_x_in;
   logic [7:0] chain_y_ff, chain_y_in;

   logic [7:0] base_x, base_y;
   logic [7:0] new_x, new_y;
   logic [7:0] pos_x, pos_y;
   logic [1:0] pri;
   logic       hide_x, hide_y;

   sre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // entries only enter while the row engine is free
   assign req.ready   = eng_idle;
   assign accept      = req.valid && req.ready;
   assign in_range    = {1'b0, req.sprite_index} < 7'(SPRITE_COUNT);
   assign frame_start = accept && in_range && (req.sprite_index == 6'd0);

   // frame start zeroes the chain before this entry uses it
   assign base_x = (req.attribute_word[CHAIN_X_BIT] && (req.sprite_index != 6'd0)) ?
                   chain_x_ff : 8'd0;
   assign base_y = (req.attribute_word[CHAIN_Y_BIT] && (req.sprite_index != 6'd0)) ?
                   chain_y_ff : 8'd0;
   assign new_x  = base_x + req.x_offset;
   assign new_y  = base_y + req.y_offset;
   assign pos_x  = new_x + cfg.scroll_x;
   assign pos_y  = new_y + cfg.scroll_y;

   assign pri    = req.attribute_word[PRI_HI_BIT:PRI_LO_BIT];
   // hidden bands; the top of each band wraps into negative positions
   assign hide_x = (pos_x > 8'(HIDE_X_LO)) && (pos_x < 8'(HIDE_HI));
   assign hide_y = (pos_y >= 8'(LINE_COUNT)) && (pos_y < 8'(HIDE_HI));
   // attribute words at most 0xff are empty entries
   assign visible = !hide_x && !hide_y && (req.attribute_word[15:8] != 8'd0) &&
                    (pri != 2'd0);
   assign start   = accept && in_range && visible;

   // chain moves on even for skipped sprites
   assign chain_x_in = (accept && in_range) ? new_x : chain_x_ff;
   assign chain_y_in = (accept && in_range) ? new_y : chain_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_x_ff <= 8'd0;
         chain_y_ff <= 8'd0;
      end else begin
         chain_x_ff <= chain_x_in;
         chain_y_ff <= chain_y_in;
      end
   end

   always_comb begin
      job.sprite_id    = req.sprite_index;
      job.pos_x        = pos_x;
      job.pos_y        = pos_y;
      job.prisel       = pri - 2'd1;
      job.tile         = req.attribute_word[TILE_W-1:0];
      job.vflip        = req.attribute_word[VFLIP_BIT];
      job.hflip        = req.attribute_word[HFLIP_BIT];
      // mono: palette 0 or 4 from the attribute, colour: number times four
      job.palette_base = cfg.mono_mode ?
                         {3'b000, req.attribute_word[MONO_PAL_BIT], 2'b00} :
                         {req.color_palette_number, 2'b00};
   end

   sre_row_engine u_row_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .frame_clear (frame_start),
      .job         (job),
      .idle        (eng_idle),
      .rsp         (rsp)
   );

endmodule

// ----- rtl/sre_ram.sv -----
// ----------------------------------------------------------------------------
// sre_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sre_csr.sv -----
// ----------------------------------------------------------------------------
// sre_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module sre_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sre_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sre_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sre_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output sre_pkg::cfg_type            cfg
);
   import sre_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_strobe;
   reg_index_type reg_idx;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_SCROLL_X:  cfg_in.scroll_x  = csr_pwdata[7:0];
            REG_SCROLL_Y:  cfg_in.scroll_y  = csr_pwdata[7:0];
            REG_MONO_MODE: cfg_in.mono_mode = csr_pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SCROLL_X:  csr_prdata = {{(CSR_DW-8){1'b0}}, cfg_ff.scroll_x};
         REG_SCROLL_Y:  csr_prdata = {{(CSR_DW-8){1'b0}}, cfg_ff.scroll_y};
         REG_MONO_MODE: csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.mono_mode};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/sre_row_engine.sv -----
// ----------------------------------------------------------------------------
// sre_row_engine
// walks the eight rows of a sprite, updates the per-line list counters in
// memory and emits row records
// ----------------------------------------------------------------------------
module sre_row_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              frame_clear,
   input  sre_pkg::job_type  job,
   output logic              idle,
   sre_rsp_if.source         rsp
);
   import sre_pkg::*;

   eng_state_type   state_ff, state_in;
   job_type         job_ff, job_in;
   logic [2:0]      row_ff, row_in;
   logic [7:0]      ln_ff, ln_in;
   logic [LINE_COUNT-1:0] row_valid_ff, row_valid_in;
   rec_type         pend_ff, pend_in;
   logic            pend_valid_ff, pend_valid_in;
   rec_type         out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic               ram_rd_en;
   logic               ram_wr_en;
   logic [ROW_W-1:0]   ram_rdata;
   count_row_type      row_cur;
   count_row_type      row_new;
   logic [COUNT_W-1:0] count;
   logic               has_room;
   logic               out_free;
   logic [7:0]         ln_next;
   rec_type            rec_new;

   assign out_free = !out_valid_ff || rsp.ready;
   assign ln_next  = job_ff.pos_y + {5'b0, row_ff};

   // entries of a line not yet touched this frame read as zero
   assign row_cur  = row_valid_ff[ln_ff[LINE_AW-1:0]] ? count_row_type'(ram_rdata) : '0;
   assign count    = row_cur[job_ff.prisel];
   assign has_room = count < COUNT_W'(LIST_MAX);

   always_comb begin
      row_new = row_cur;
      row_new[job_ff.prisel] = count + COUNT_W'(1);
   end

   always_comb begin
      rec_new.line         = ln_ff;
      rec_new.priority_res = job_ff.prisel;
      rec_new.list_slot    = count[5:0];
      rec_new.sprite_id    = job_ff.sprite_id;
      rec_new.tile_row     = {job_ff.tile, job_ff.vflip ? ~row_ff : row_ff};
      rec_new.screen_x     = job_ff.pos_x;
      rec_new.palette_base = job_ff.palette_base;
      rec_new.hflip        = job_ff.hflip;
      rec_new.last         = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      row_in        = row_ff;
      ln_in         = ln_ff;
      row_valid_in  = row_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;

      if (frame_clear) begin
         row_valid_in = '0;
      end

      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               job_in   = job;
               row_in   = 3'd0;
               state_in = ENG_READ;
            end
         end
         ENG_READ: begin
            ln_in = ln_next;
            if (ln_next < 8'(LINE_COUNT)) begin
               ram_rd_en = 1'b1;
               state_in  = ENG_WRITE;
            end else if (row_ff == 3'd7) begin
               state_in = ENG_FLUSH;
            end else begin
               row_in = row_ff + 3'd1;
            end
         end
         ENG_WRITE: begin
            // hold while the previous record cannot be handed on
            if (!(has_room && pend_valid_ff && !out_free)) begin
               if (has_room) begin
                  ram_wr_en = 1'b1;
                  row_valid_in[ln_ff[LINE_AW-1:0]] = 1'b1;
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  pend_in       = rec_new;
                  pend_valid_in = 1'b1;
               end
               if (row_ff == 3'd7) begin
                  state_in = ENG_FLUSH;
               end else begin
                  row_in   = row_ff + 3'd1;
                  state_in = ENG_READ;
               end
            end
         end
         ENG_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ENG_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_IDLE;
         row_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      row_ff  <= row_in;
      ln_ff   <= ln_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   sre_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LINE_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ln_ff[LINE_AW-1:0]),
      .wr_data (ROW_W'(row_new)),
      .rd_en   (ram_rd_en),
      .rd_addr (ln_next[LINE_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign idle             = (state_ff == ENG_IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.line         = out_ff.line;
   assign rsp.priority_res = out_ff.priority_res;
   assign rsp.list_slot    = out_ff.list_slot;
   assign rsp.sprite_id    = out_ff.sprite_id;
   assign rsp.tile_row     = out_ff.tile_row;
   assign rsp.screen_x     = out_ff.screen_x;
   assign rsp.palette_base = out_ff.palette_base;
   assign rsp.hflip        = out_ff.hflip;
   assign rsp.last         = out_ff.last;

endmodule

// ----- tb/sv/tb_sprite_row_evaluator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_row_evaluator_unit
// self-checking bench for the sprite row evaluator
// ----------------------------------------------------------------------------
// sprite entries are fed from a queue into the req channel by a clocked
// driver; every accepted word runs through a row predictor that keeps its own
// chain position, per-line list counters and register copies, and queues the
// row records it expects. a clocked monitor takes rsp words and compares them
// field by field with the oldest expected record. both sides idle at random
// in bursts. the run walks several register settings: a directed phase of
// band edges, chaining and flips, random frames, and a crowded phase that
// overfills the per-line lists.
// ----------------------------------------------------------------------------
module tb_sprite_row_evaluator_unit;
   import sre_pkg::*;

   // watchdog limit, set well above the slowest legal run
   localparam int CYCLE_LIMIT  = 200000;
   // a skipped sprite gives no word back, so settle this long before a write
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 40;

   typedef struct packed {
      logic [5:0]  sprite_index;
      logic [15:0] attribute_word;
      logic [7:0]  x_offset;
      logic [7:0]  y_offset;
      logic [3:0]  color_palette_number;
   } sprite_entry_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   sre_req_if req_bus ();
   sre_rsp_if rsp_bus ();

   sprite_row_evaluator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // stimulus and expectation stores
   sprite_entry_type entry_queue[$];
   rec_type          rows_due[$];
   sprite_entry_type entry_on_bus;
   int unsigned      entries_queued = 0;
   int unsigned      entries_taken  = 0;
   int unsigned      errors         = 0;
   int unsigned      cycle_count    = 0;

   // idling state of both sides
   int feed_gap   = 0;
   int feed_burst = 0;
   bit feed_slack = 1'b0;
   bit feed_fire;
   int sink_stall = 0;
   int sink_burst = 0;
   bit sink_slack = 1'b0;

   // predictor state and register copies
   logic [7:0]         pos_chain_x;
   logic [7:0]         pos_chain_y;
   logic [COUNT_W-1:0] line_fill [PRI_LISTS][LINE_COUNT];
   logic [7:0]         cfg_scroll_x;
   logic [7:0]         cfg_scroll_y;
   logic               cfg_mono;

   task automatic clear_line_fill();
      for (int p = 0; p < PRI_LISTS; p++)
         for (int l = 0; l < LINE_COUNT; l++)
            line_fill[p][l] = '0;
   endtask

   function automatic logic [15:0] make_attr(input logic [8:0] tile, input logic chain_y,
                                             input logic chain_x, input logic [1:0] pri,
                                             input logic mono, input logic vflip,
                                             input logic hflip);
      return {hflip, vflip, mono, pri, chain_x, chain_y, tile};
   endfunction

   // works out the row records one sprite entry gives and queues them
   task automatic predict_rows(input sprite_entry_type e);
      logic [7:0]  px;
      logic [7:0]  py;
      logic [7:0]  ln;
      logic [1:0]  pri;
      logic [1:0]  sel;
      logic [5:0]  pbase;
      logic [11:0] tile_base;
      logic        vflip;
      rec_type     rec;
      rec_type     batch[$];
      if (int'(e.sprite_index) >= SPRITE_COUNT) return;
      // frame start clears the chain and every list counter first
      if (e.sprite_index == 6'd0) begin
         pos_chain_x = '0;
         pos_chain_y = '0;
         clear_line_fill();
      end
      // chain moves even when the sprite turns out hidden
      pos_chain_x = (e.attribute_word[CHAIN_X_BIT] ? pos_chain_x : 8'd0) + e.x_offset;
      pos_chain_y = (e.attribute_word[CHAIN_Y_BIT] ? pos_chain_y : 8'd0) + e.y_offset;
      px  = pos_chain_x + cfg_scroll_x;
      py  = pos_chain_y + cfg_scroll_y;
      pri = e.attribute_word[PRI_HI_BIT:PRI_LO_BIT];
      if ((px > HIDE_X_LO && px < HIDE_HI) || (py >= LINE_COUNT && py < HIDE_HI) ||
          e.attribute_word <= 16'h00ff || pri == 2'd0)
         return;
      sel       = pri - 2'd1;
      vflip     = e.attribute_word[VFLIP_BIT];
      pbase     = cfg_mono ? {3'b000, e.attribute_word[MONO_PAL_BIT], 2'b00}
                           : {e.color_palette_number, 2'b00};
      tile_base = {e.attribute_word[TILE_W-1:0], 3'b000};
      for (int j = 0; j < 8; j++) begin
         ln = py + 8'(j);
         // off-screen rows and full lists give nothing
         if (ln >= LINE_COUNT) continue;
         if (line_fill[sel][ln] >= LIST_MAX) continue;
         rec.line         = ln;
         rec.priority_res = sel;
         rec.list_slot    = line_fill[sel][ln][5:0];
         rec.sprite_id    = e.sprite_index;
         rec.tile_row     = tile_base + (vflip ? 12'(7 - j) : 12'(j));
         rec.screen_x     = px;
         rec.palette_base = pbase;
         rec.hflip        = e.attribute_word[HFLIP_BIT];
         rec.last         = 1'b0;
         line_fill[sel][ln] = line_fill[sel][ln] + 1'b1;
         batch.push_back(rec);
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) rows_due.push_back(batch[k]);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (errors < REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_row();
      rec_type want;
      if (rows_due.size() == 0) begin
         if (errors < REPORT_MAX)
            $display("%0t: row record with none expected, expected nothing, %s %0d %s %0d",
                     $time, "actual line", rsp_bus.line, "sprite", rsp_bus.sprite_id);
         errors++;
         return;
      end
      want = rows_due.pop_front();
      check_field("line", want.line, rsp_bus.line);
      check_field("priority_res", want.priority_res, rsp_bus.priority_res);
      check_field("list_slot", want.list_slot, rsp_bus.list_slot);
      check_field("sprite_id", want.sprite_id, rsp_bus.sprite_id);
      check_field("tile_row", want.tile_row, rsp_bus.tile_row);
      check_field("screen_x", want.screen_x, rsp_bus.screen_x);
      check_field("palette_base", want.palette_base, rsp_bus.palette_base);
      check_field("hflip", want.hflip, rsp_bus.hflip);
      check_field("last", want.last, rsp_bus.last);
   endtask

   // driver: one word per sprite entry, gap drawn at each handshake
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         feed_gap = 0;
      end else begin
         feed_fire = req_bus.valid && req_bus.ready;
         if (feed_fire) begin
            predict_rows(entry_on_bus);
            entries_taken++;
            // bursts with and without idling
            if (feed_burst == 0) begin
               feed_burst = $urandom_range(4, 24);
               feed_slack = ($urandom_range(0, 2) != 0);
            end
            feed_burst--;
            feed_gap = feed_slack ? $urandom_range(0, 3) : 0;
         end else if (feed_gap > 0) begin
            feed_gap--;
         end
         // valid stays up across back-to-back words, one assignment per edge
         if (feed_fire || !req_bus.valid) begin
            if (feed_gap == 0 && entry_queue.size() > 0) begin
               entry_on_bus = entry_queue.pop_front();
               req_bus.valid                <= 1'b1;
               req_bus.sprite_index         <= entry_on_bus.sprite_index;
               req_bus.attribute_word       <= entry_on_bus.attribute_word;
               req_bus.x_offset             <= entry_on_bus.x_offset;
               req_bus.y_offset             <= entry_on_bus.y_offset;
               req_bus.color_palette_number <= entry_on_bus.color_palette_number;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each rsp word, stall drawn after each one
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_row();
            if (sink_burst == 0) begin
               sink_burst = $urandom_range(4, 32);
               sink_slack = ($urandom_range(0, 2) != 0);
            end
            sink_burst--;
            sink_stall = sink_slack ? $urandom_range(0, 3) : 0;
         end else if (sink_stall > 0) begin
            sink_stall--;
         end
         rsp_bus.ready <= (sink_stall == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d row records outstanding", $time, rows_due.size());
         $display("tb_sprite_row_evaluator_unit failed");
         $finish;
      end
   end

   task automatic push_entry(input sprite_entry_type e);
      entry_queue.push_back(e);
      entries_queued++;
   endtask

   task automatic wait_idle();
      while (entries_taken != entries_queued || rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type which, input logic [7:0] value,
                            input int width);
      logic [31:0] noise;
      noise = $urandom();
      // setup cycle, then access until pready
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= (noise << width) | 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (which)
         REG_SCROLL_X:  cfg_scroll_x = value;
         REG_SCROLL_Y:  cfg_scroll_y = value;
         REG_MONO_MODE: cfg_mono     = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] sx, input logic [7:0] sy, input logic mono);
      csr_write(REG_SCROLL_X, sx, 8);
      csr_write(REG_SCROLL_Y, sy, 8);
      csr_write(REG_MONO_MODE, {7'd0, mono}, 1);
   endtask

   // mostly well-formed visible sprites aimed at the screen, some raw noise
   function automatic sprite_entry_type random_entry(input logic [5:0] idx);
      sprite_entry_type e;
      logic             chx;
      logic             chy;
      logic [7:0]       tx;
      logic [7:0]       ty;
      if ($urandom_range(0, 5) == 0) begin
         e.sprite_index         = 6'($urandom);
         e.attribute_word       = 16'($urandom);
         e.x_offset             = 8'($urandom);
         e.y_offset             = 8'($urandom);
         e.color_palette_number = 4'($urandom);
         return e;
      end
      chx = ($urandom_range(0, 3) == 0);
      chy = ($urandom_range(0, 3) == 0);
      tx  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(249, 255))
                                        : 8'($urandom_range(0, 167));
      ty  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(249, 255))
                                        : 8'($urandom_range(0, 151));
      e.sprite_index         = idx;
      e.attribute_word       = make_attr(9'($urandom), chy, chx, 2'($urandom_range(1, 3)),
                                         1'($urandom), 1'($urandom), 1'($urandom));
      e.x_offset             = chx ? 8'($urandom_range(0, 15)) : tx - cfg_scroll_x;
      e.y_offset             = chy ? 8'($urandom_range(0, 15)) : ty - cfg_scroll_y;
      e.color_palette_number = 4'($urandom);
      return e;
   endfunction

   // frames of rising indices, most opened by index 0
   task automatic push_frames(input int count);
      int         made;
      int         len;
      logic [5:0] idx;
      made = 0;
      while (made < count) begin
         len = $urandom_range(1, 12);
         idx = ($urandom_range(0, 7) != 0) ? 6'd0 : 6'($urandom_range(1, 63));
         for (int k = 0; k < len && made < count; k++) begin
            push_entry(random_entry(idx));
            made++;
            if (idx == 6'd63) break;
            idx++;
         end
      end
   endtask

   // one frame of sprites stacked on a few lines, enough to fill the lists
   task automatic push_crowd(input int count);
      logic [1:0] pri;
      logic [7:0] ty;
      logic [7:0] tx;
      for (int k = 0; k < count; k++) begin
         // mostly the top list, so that one list per line runs over
         pri = ((k % 10) == 9) ? 2'($urandom_range(1, 2)) : 2'd3;
         ty  = 8'($urandom_range(10, 12));
         tx  = 8'($urandom_range(0, 167));
         push_entry(sprite_entry_type'{(k == 0) ? 6'd0 : 6'($urandom_range(1, 63)),
                    make_attr(9'($urandom), 1'b0, 1'b0, pri, 1'($urandom),
                              1'($urandom), 1'($urandom)),
                    tx - cfg_scroll_x, ty - cfg_scroll_y, 4'($urandom)});
      end
   endtask

   initial begin
      // every input known from time zero
      csr_psel                     = 1'b0;
      csr_penable                  = 1'b0;
      csr_pwrite                   = 1'b0;
      csr_paddr                    = '0;
      csr_pwdata                   = '0;
      req_bus.valid                = 1'b0;
      req_bus.sprite_index         = '0;
      req_bus.attribute_word       = '0;
      req_bus.x_offset             = '0;
      req_bus.y_offset             = '0;
      req_bus.color_palette_number = '0;
      rsp_bus.ready                = 1'b0;
      pos_chain_x                  = '0;
      pos_chain_y                  = '0;
      cfg_scroll_x                 = '0;
      cfg_scroll_y                 = '0;
      cfg_mono                     = 1'b0;
      clear_line_fill();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, no scroll, colour palettes
      set_config(8'd0, 8'd0, 1'b0);
      // frame start with tile, priority and flag fields at their top, chain bits clear
      push_entry(sprite_entry_type'{6'd0, make_attr(9'h1ff, 1'b0, 1'b0, 2'd3, 1'b1, 1'b1, 1'b1),
                 8'd0, 8'd0, 4'd15});
      // last visible column and last visible line, only one row on screen
      push_entry(sprite_entry_type'{6'd1, make_attr(9'h000, 1'b0, 1'b0, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd167, 8'd151, 4'd0});
      // hidden x band edges
      push_entry(sprite_entry_type'{6'd2, make_attr(9'h005, 1'b0, 1'b0, 2'd2, 1'b0, 1'b1, 1'b0),
                 8'd168, 8'd40, 4'd3});
      push_entry(sprite_entry_type'{6'd3, make_attr(9'h006, 1'b0, 1'b0, 2'd2, 1'b0, 1'b0, 1'b1),
                 8'd248, 8'd40, 4'd4});
      // first negative position in both axes, rows wrap onto line 0
      push_entry(sprite_entry_type'{6'd4, make_attr(9'h0aa, 1'b0, 1'b0, 2'd3, 1'b0, 1'b0, 1'b0),
                 8'd249, 8'd249, 4'd5});
      // hidden y band edges
      push_entry(sprite_entry_type'{6'd5, make_attr(9'h055, 1'b0, 1'b0, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd20, 8'd152, 4'd6});
      push_entry(sprite_entry_type'{6'd6, make_attr(9'h055, 1'b0, 1'b0, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd20, 8'd248, 4'd7});
      // low attribute words and zero priority are skipped
      push_entry(sprite_entry_type'{6'd7, make_attr(9'h0ff, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0),
                 8'd30, 8'd30, 4'd8});
      push_entry(sprite_entry_type'{6'd8, make_attr(9'h100, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0),
                 8'd30, 8'd30, 4'd9});
      // top offsets, rows from line 0 upward
      push_entry(sprite_entry_type'{6'd9, make_attr(9'h123, 1'b0, 1'b0, 2'd2, 1'b0, 1'b0, 1'b1),
                 8'd255, 8'd255, 4'd8});
      // chained on both axes, then on x alone
      push_entry(sprite_entry_type'{6'd10, make_attr(9'h124, 1'b1, 1'b1, 2'd2, 1'b0, 1'b1, 1'b0),
                 8'd10, 8'd20, 4'd10});
      push_entry(sprite_entry_type'{6'd11, make_attr(9'h125, 1'b0, 1'b1, 2'd3, 1'b0, 1'b0, 1'b0),
                 8'd240, 8'd30, 4'd11});
      // skipped sprite still moves the chain for the next one
      push_entry(sprite_entry_type'{6'd12, make_attr(9'h1ff, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0),
                 8'd100, 8'd100, 4'd12});
      push_entry(sprite_entry_type'{6'd13, make_attr(9'h001, 1'b1, 1'b1, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd0, 8'd0, 4'd13});
      // new frame: chain relative to zero, counters start again
      push_entry(sprite_entry_type'{6'd0, make_attr(9'h002, 1'b1, 1'b1, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd50, 8'd60, 4'd1});
      push_entry(sprite_entry_type'{6'd1, make_attr(9'h003, 1'b0, 1'b0, 2'd1, 1'b0, 1'b0, 1'b0),
                 8'd90, 8'd62, 4'd2});
      push_entry(sprite_entry_type'{6'd63, make_attr(9'h004, 1'b0, 1'b0, 2'd2, 1'b1, 1'b0, 1'b0),
                 8'd0, 8'd0, 4'd14});
      wait_idle();

      // full scroll, mono palettes, then random frames
      set_config(8'd255, 8'd255, 1'b1);
      push_entry(sprite_entry_type'{6'd0, make_attr(9'h0f0, 1'b0, 1'b0, 2'd3, 1'b1, 1'b0, 1'b0),
                 8'd1, 8'd1, 4'd0});
      push_entry(sprite_entry_type'{6'd1, make_attr(9'h0f1, 1'b0, 1'b0, 2'd3, 1'b0, 1'b0, 1'b1),
                 8'd1, 8'd1, 4'd15});
      push_frames(25);
      wait_idle();

      // random scroll, colour palettes, lists overfilled
      set_config(8'($urandom), 8'($urandom), 1'b0);
      push_crowd(80);
      wait_idle();

      // mid scroll, mono palettes, random frames
      set_config(8'h80, 8'($urandom), 1'b1);
      push_frames(25);
      wait_idle();

      if (errors == 0)
         $display("tb_sprite_row_evaluator_unit passed");
      else
         $display("tb_sprite_row_evaluator_unit failed");
      $finish;
   end

endmodule
